// ===== sv/sas_pkg.sv =====
// Shared types, register codes and constants for the sprite animation sequencer.
package sas_pkg;

    localparam int SAS_MAX_FRAMES = 4096;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAME    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_STEP     = 3'd7;

    // Animation modes
    localparam logic [1:0] MODE_LOOP     = 2'd0;
    localparam logic [1:0] MODE_SHRINK   = 2'd1;
    localparam logic [1:0] MODE_GROW     = 2'd2;
    localparam logic [1:0] MODE_PINGPONG = 2'd3;

    // Request opcodes
    localparam logic OP_RENDER = 1'b0;
    localparam logic OP_PLAY   = 1'b1;

    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               op;
        logic [31:0]        now_time;
        logic               play;
        logic signed [15:0] base_x;
        logic signed [15:0] base_y;
        logic [14:0]        base_w;
        logic [14:0]        base_h;
        logic [15:0]        base_image;
    } sas_in_t;

    typedef struct packed {
        logic               draw;
        logic [15:0]        image_index;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_w;
        logic signed [15:0] out_h;
        logic               ended;
    } sas_out_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [12:0] frame_count;
        logic [31:0] time_limit;
        logic [31:0] tick_interval;
        logic [31:0] loop_limit;
        logic        hold_frame;
        logic [15:0] size_limit;
        logic [15:0] size_step;
    } sas_cfg_t;

    typedef struct packed {
        logic               playing;
        logic [31:0]        limit_start;
        logic [31:0]        tick_start;
        logic signed [13:0] frame_pos;
        logic [31:0]        loop_count;
        logic [23:0]        grow_size;
        logic               forward;
        logic               end_mark;
    } sas_state_t;

endpackage

// ===== sv/sas_step.sv =====
// Per-request update: sequencer state transition and draw result.
module sas_step #(
    parameter int MAX_FRAMES = sas_pkg::SAS_MAX_FRAMES
) (
    input  sas_pkg::sas_cfg_t   cfg,
    input  sas_pkg::sas_state_t state,
    input  sas_pkg::sas_in_t    req,
    output sas_pkg::sas_state_t state_next,
    output sas_pkg::sas_out_t   result
);
    import sas_pkg::*;

    localparam logic signed [13:0] POS_MAX = 14'sd8191;
    localparam logic signed [13:0] POS_MIN = -14'sd8192;

    // Truncate toward zero after an arithmetic shift, then clamp to 16-bit signed
    function automatic logic signed [15:0] div_sat(input logic signed [27:0] v,
                                                   input logic [3:0] sh);
        logic [27:0]        mask;
        logic signed [27:0] q;
        mask = (28'd1 << sh) - 28'd1;
        q    = v >>> sh;
        if (v < 0 && (v & mask) != 28'd0)
        begin
            q = q + 28'sd1;
        end
        if (q > 28'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (q < -28'sd32768)
        begin
            return 16'sh8000;
        end
        return q[15:0];
    endfunction

    function automatic logic loop_ok(input logic [31:0] cnt, input logic [31:0] lim);
        return (lim == ALL_ONES32) || (cnt < lim);
    endfunction

    logic [13:0]        n_frames;
    logic signed [14:0] n_s;
    logic signed [14:0] pos_s;
    logic               active;
    logic               tick;
    logic [24:0]        sum;
    logic [24:0]        lim;
    logic               wrap;
    logic signed [27:0] x_base;
    logic signed [27:0] y_base;
    logic signed [27:0] w_base;
    logic signed [27:0] h_base;
    logic signed [27:0] g_ext;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rw;
    logic signed [15:0] rh;

    always_comb
    begin
        if (cfg.frame_count == 13'd0)
        begin
            n_frames = 14'd1;
        end
        else if ({1'b0, cfg.frame_count} > 14'(MAX_FRAMES))
        begin
            n_frames = 14'(MAX_FRAMES);
        end
        else
        begin
            n_frames = {1'b0, cfg.frame_count};
        end
        n_s = $signed({1'b0, n_frames});
    end

    always_comb
    begin
        state_next = state;
        result     = '0;
        active     = 1'b0;
        tick       = 1'b0;
        sum        = '0;
        lim        = {1'b0, cfg.size_limit, 8'd0};
        wrap       = 1'b0;
        pos_s      = 15'(state.frame_pos);
        x_base     = 28'(req.base_x) <<< 9;
        y_base     = 28'(req.base_y) <<< 9;
        w_base     = $signed({13'd0, req.base_w}) <<< 8;
        h_base     = $signed({13'd0, req.base_h}) <<< 8;
        g_ext      = '0;
        rx         = req.base_x;
        ry         = req.base_y;
        rw         = $signed({1'b0, req.base_w});
        rh         = $signed({1'b0, req.base_h});

        if (req.op == OP_PLAY)
        begin
            state_next.limit_start = req.now_time;
            state_next.tick_start  = req.now_time;
            state_next.frame_pos   = '0;
            state_next.end_mark    = 1'b0;
            state_next.loop_count  = '0;
            state_next.playing     = req.play;
        end
        else
        begin
            active = state.playing && loop_ok(state.loop_count, cfg.loop_limit)
                     && ((req.now_time - state.limit_start) <= cfg.time_limit);
            tick   = (req.now_time - state.tick_start) >= cfg.tick_interval;

            if (active)
            begin
                if (tick)
                begin
                    state_next.tick_start = req.now_time;
                    case (cfg.mode)
                        MODE_LOOP:
                        begin
                            if (pos_s >= n_s)
                            begin
                                state_next.frame_pos = '0;
                                wrap = 1'b1;
                            end
                        end
                        MODE_SHRINK, MODE_GROW:
                        begin
                            if ((cfg.mode == MODE_SHRINK && pos_s >= n_s) ||
                                (cfg.mode == MODE_GROW && pos_s >= n_s - 15'sd1))
                            begin
                                state_next.frame_pos = '0;
                            end
                            sum = {1'b0, state.grow_size} + {9'd0, cfg.size_step};
                            if ((cfg.mode == MODE_SHRINK && sum > lim) ||
                                (cfg.mode == MODE_GROW && sum >= lim))
                            begin
                                sum = '0;
                                wrap = 1'b1;
                                state_next.end_mark = 1'b1;
                            end
                            state_next.grow_size = sum[23:0];
                            g_ext = $signed({4'd0, sum[23:0]});
                            if (cfg.mode == MODE_SHRINK)
                            begin
                                rx = div_sat(x_base + g_ext, 4'd9);
                                ry = div_sat(y_base + g_ext, 4'd9);
                                rw = div_sat(w_base - g_ext, 4'd8);
                                rh = div_sat(h_base - g_ext, 4'd8);
                            end
                            else
                            begin
                                rx = div_sat(x_base - g_ext, 4'd9);
                                ry = div_sat(y_base - g_ext, 4'd9);
                                rw = div_sat(w_base + g_ext, 4'd8);
                                rh = div_sat(h_base + g_ext, 4'd8);
                            end
                        end
                        MODE_PINGPONG:
                        begin
                            if (pos_s >= n_s)
                            begin
                                state_next.frame_pos = 14'(n_frames - 14'd1);
                                state_next.forward   = 1'b0;
                            end
                            else if (pos_s < 15'sd0)
                            begin
                                state_next.frame_pos = '0;
                                state_next.forward   = 1'b1;
                                state_next.end_mark  = 1'b1;
                                wrap = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (wrap && state.loop_count != ALL_ONES32)
                    begin
                        state_next.loop_count = state.loop_count + 32'd1;
                    end
                end

                if (loop_ok(state_next.loop_count, cfg.loop_limit))
                begin
                    result.draw        = 1'b1;
                    result.image_index = req.base_image + 16'(state_next.frame_pos);
                    result.out_x       = rx;
                    result.out_y       = ry;
                    result.out_w       = rw;
                    result.out_h       = rh;
                end

                if (!cfg.hold_frame)
                begin
                    if (state_next.forward)
                    begin
                        if (state_next.frame_pos < POS_MAX)
                        begin
                            state_next.frame_pos = state_next.frame_pos + 14'sd1;
                        end
                    end
                    else if (state_next.frame_pos > POS_MIN)
                    begin
                        state_next.frame_pos = state_next.frame_pos - 14'sd1;
                    end
                end
            end
            result.ended = state_next.end_mark;
        end
    end

endmodule

// ===== sv/sprite_animation_sequencer.sv =====
// Top level: configuration registers, request register, sequencer state and result register.
// Sprite animation sequencer. Takes one request per clock and returns exactly one result per
// request, in order. A request is captured in an input register; from there the whole
// state update (interval tick, mode step, loop count, frame step, rectangle scaling) runs in
// one combinational stage and writes the result register once that register is free, and the
// sustained rate is one request per cycle; the only limit is out_ready, and a waiting result
// holds off at most one further request in the input register. Configuration writes are
// always taken (cfg_ready is tied high) and should be issued only while no request is in
// flight. A play request (op 1) restarts the strip but keeps the ping-pong direction.
module sprite_animation_sequencer #(
    parameter int MAX_FRAMES = sas_pkg::SAS_MAX_FRAMES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sas_pkg::sas_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sas_pkg::sas_out_t                   out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sas_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sas_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import sas_pkg::*;

    sas_cfg_t   cfg_reg;
    sas_state_t state_reg;
    sas_state_t state_next;
    sas_in_t    req_reg;
    logic       req_valid_reg;
    logic       req_valid_next;
    sas_out_t   out_data_reg;
    sas_out_t   result;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       req_go;
    logic       in_accept;

    sas_step #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .req        (req_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        req_go         = req_valid_reg && out_free;
        in_ready       = !req_valid_reg || out_free;
        in_accept      = in_valid && in_ready;
        req_valid_next = (req_valid_reg && !req_go) || in_accept;
        out_valid_next = req_go || (out_valid_reg && !out_ready);
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg         <= 1'b0;
            out_valid_reg         <= 1'b0;
            cfg_reg.mode          <= MODE_LOOP;
            cfg_reg.frame_count   <= 13'd1;
            cfg_reg.time_limit    <= ALL_ONES32;
            cfg_reg.tick_interval <= 32'd1;
            cfg_reg.loop_limit    <= ALL_ONES32;
            cfg_reg.hold_frame    <= 1'b0;
            cfg_reg.size_limit    <= '0;
            cfg_reg.size_step     <= '0;
            state_reg.playing     <= 1'b0;
            state_reg.limit_start <= '0;
            state_reg.tick_start  <= '0;
            state_reg.frame_pos   <= '0;
            state_reg.loop_count  <= '0;
            state_reg.grow_size   <= '0;
            state_reg.forward     <= 1'b1;
            state_reg.end_mark    <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
            if (req_go)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE:          cfg_reg.mode          <= cfg_data[1:0];
                    CFG_FRAME_COUNT:   cfg_reg.frame_count   <= cfg_data[12:0];
                    CFG_TIME_LIMIT:    cfg_reg.time_limit    <= cfg_data;
                    CFG_TICK_INTERVAL: cfg_reg.tick_interval <= cfg_data;
                    CFG_LOOP_LIMIT:    cfg_reg.loop_limit    <= cfg_data;
                    CFG_HOLD_FRAME:    cfg_reg.hold_frame    <= cfg_data[0];
                    CFG_SIZE_LIMIT:    cfg_reg.size_limit    <= cfg_data[15:0];
                    CFG_SIZE_STEP:     cfg_reg.size_step     <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg <= in_data;
        end
        if (req_go)
        begin
            out_data_reg <= result;
        end
    end

endmodule

// ===== sv/sas_checker.sv =====
// Port-level checks for the sprite animation sequencer, bound to the top level.
module sas_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input sas_pkg::sas_out_t              out_data
);
    import sas_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // With no result pending, the request side is never blocked
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request blocked with empty result stage");

    // A taken request passes the input register and reaches the result register when downstream is ready
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready |=> out_valid)
        else $error("request did not advance to result");

    // A result without draw carries no frame or rectangle
    a_no_draw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.draw |->
            out_data.image_index == 16'd0 && out_data.out_x == 16'sd0 &&
            out_data.out_y == 16'sd0 && out_data.out_w == 16'sd0 &&
            out_data.out_h == 16'sd0)
        else $error("non-draw result carries rectangle data");

endmodule

bind sprite_animation_sequencer sas_checker u_sas_checker (.*);

// ===== test/tb_sprite_animation_sequencer.sv =====
// Self-checking testbench for the sprite animation sequencer: directed cases and random runs.
`timescale 1ns / 1ps

module tb_sprite_animation_sequencer;
    import sas_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int FRAME_POS_MAX = 8191;
    localparam int FRAME_POS_MIN = -8192;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    sas_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready;
    sas_out_t              out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predicted copy of the register file and sequencer state
    sas_cfg_t    regs;
    logic        seq_playing;
    logic [31:0] seq_limit_start;
    logic [31:0] seq_tick_start;
    int          seq_frame;
    logic [31:0] seq_loops;
    logic [23:0] seq_size;
    logic        seq_fwd;
    logic        seq_ended;

    sas_out_t    pending_frames[$];
    int          mismatches;
    int          cycle_count;
    int          stall_left;
    logic        gaps_on;

    sprite_animation_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic loops_left();
        return (regs.loop_limit == ALL_ONES32) || (seq_loops < regs.loop_limit);
    endfunction

    function automatic void bump_loops();
        if (seq_loops != ALL_ONES32)
            seq_loops++;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_MODE:          regs.mode          = val[1:0];
            CFG_FRAME_COUNT:   regs.frame_count   = val[12:0];
            CFG_TIME_LIMIT:    regs.time_limit    = val;
            CFG_TICK_INTERVAL: regs.tick_interval = val;
            CFG_LOOP_LIMIT:    regs.loop_limit    = val;
            CFG_HOLD_FRAME:    regs.hold_frame    = val[0];
            CFG_SIZE_LIMIT:    regs.size_limit    = val[15:0];
            CFG_SIZE_STEP:     regs.size_step     = val[15:0];
            default: ;
        endcase
    endfunction

    // Advances the predicted sequencer by one request and returns the frame it should report.
    function automatic sas_out_t sequence_step(input sas_in_t req);
        sas_out_t           res;
        int                 n;
        longint             bx, by, bw, bh, gs, sgn;
        logic signed [15:0] rx, ry, rw, rh;
        logic [31:0]        sum, lim;
        logic               shrink, wrap;
        res = '0;
        if (req.op == OP_PLAY)
        begin
            seq_limit_start = req.now_time;
            seq_tick_start  = req.now_time;
            seq_frame       = 0;
            seq_ended       = 1'b0;
            seq_loops       = '0;
            seq_playing     = req.play;
            return res;
        end
        if (seq_playing && loops_left() && (req.now_time - seq_limit_start) <= regs.time_limit)
        begin
            n = regs.frame_count;
            if (n < 1)
                n = 1;
            if (n > SAS_MAX_FRAMES)
                n = SAS_MAX_FRAMES;
            rx = req.base_x;
            ry = req.base_y;
            rw = {1'b0, req.base_w};
            rh = {1'b0, req.base_h};
            if ((req.now_time - seq_tick_start) >= regs.tick_interval)
            begin
                seq_tick_start = req.now_time;
                case (regs.mode)
                    MODE_LOOP:
                    begin
                        if (seq_frame > n - 1)
                        begin
                            seq_frame = 0;
                            bump_loops();
                        end
                    end
                    MODE_SHRINK, MODE_GROW:
                    begin
                        shrink = (regs.mode == MODE_SHRINK);
                        if (shrink ? (seq_frame > n - 1) : (seq_frame >= n - 1))
                            seq_frame = 0;
                        lim  = {8'd0, regs.size_limit, 8'd0};
                        sum  = seq_size + regs.size_step;
                        wrap = shrink ? (sum > lim) : (sum >= lim);
                        if (wrap)
                        begin
                            sum = '0;
                            bump_loops();
                            seq_ended = 1'b1;
                        end
                        seq_size = sum[23:0];
                        gs  = seq_size;
                        sgn = shrink ? 1 : -1;
                        bx  = $signed(req.base_x);
                        by  = $signed(req.base_y);
                        bw  = req.base_w;
                        bh  = req.base_h;
                        // shrink moves the corner in and the size down, grow the opposite
                        rx = clip16((bx * 512 + sgn * gs) / 512);
                        ry = clip16((by * 512 + sgn * gs) / 512);
                        rw = clip16((bw * 256 - sgn * gs) / 256);
                        rh = clip16((bh * 256 - sgn * gs) / 256);
                    end
                    default:
                    begin
                        if (seq_frame >= n)
                        begin
                            seq_frame = n - 1;
                            seq_fwd   = 1'b0;
                        end
                        if (seq_frame < 0)
                        begin
                            bump_loops();
                            seq_frame = 0;
                            seq_fwd   = 1'b1;
                            seq_ended = 1'b1;
                        end
                    end
                endcase
            end
            if (loops_left())
            begin
                res.draw        = 1'b1;
                res.image_index = req.base_image + seq_frame[15:0];
                res.out_x       = rx;
                res.out_y       = ry;
                res.out_w       = rw;
                res.out_h       = rh;
            end
            if (!regs.hold_frame)
            begin
                if (seq_fwd)
                begin
                    if (seq_frame < FRAME_POS_MAX)
                        seq_frame++;
                end
                else if (seq_frame > FRAME_POS_MIN)
                begin
                    seq_frame--;
                end
            end
        end
        res.ended = seq_ended;
        return res;
    endfunction

    // Track every handshake at the clock edge and check results in order.
    always @(posedge clk)
    begin
        sas_out_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                pending_frames.push_back(sequence_step(in_data));
            if (out_valid && out_ready)
            begin
                if (pending_frames.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at %0t: draw=%0d img=%0d", $realtime,
                                 out_data.draw, out_data.image_index);
                end
                else
                begin
                    want = pending_frames.pop_front();
                    if (out_data.draw !== want.draw || out_data.image_index !== want.image_index
                        || out_data.out_x !== want.out_x || out_data.out_y !== want.out_y
                        || out_data.out_w !== want.out_w || out_data.out_h !== want.out_h
                        || out_data.ended !== want.ended)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected draw=%0d img=%0d x=%0d y=%0d w=%0d h=%0d end=%0d",
                                     want.draw, want.image_index, want.out_x, want.out_y,
                                     want.out_w, want.out_h, want.ended);
                            $display("  actual   draw=%0d img=%0d x=%0d y=%0d w=%0d h=%0d end=%0d",
                                     out_data.draw, out_data.image_index, out_data.out_x,
                                     out_data.out_y, out_data.out_w, out_data.out_h,
                                     out_data.ended);
                        end
                    end
                end
            end
        end
    end

    // mostly short idles, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // result side back-pressure
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (gaps_on && $urandom_range(0, 2) == 0)
                    stall_left = idle_cycles();
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_req(input sas_in_t req);
        int g;
        g = gaps_on ? idle_cycles() : 0;
        @(negedge clk);
        if (g > 0)
        begin
            in_valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // block is idle once every request has produced its result
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic sas_in_t make_req(input logic op, input logic [31:0] now,
                                         input logic play_bit);
        sas_in_t r;
        r.op         = op;
        r.now_time   = now;
        r.play       = play_bit;
        r.base_x     = 16'($urandom);
        r.base_y     = 16'($urandom);
        r.base_w     = 15'($urandom);
        r.base_h     = 15'($urandom);
        r.base_image = 16'($urandom);
        return r;
    endfunction

    task automatic render_at(input logic [31:0] now);
        send_req(make_req(OP_RENDER, now, 1'($urandom)));
    endtask

    task automatic play_at(input logic [31:0] now, input logic play_bit);
        send_req(make_req(OP_PLAY, now, play_bit));
    endtask

    task automatic render_rect(input logic [31:0] now, input logic [15:0] x,
                               input logic [15:0] y, input logic [14:0] w, input logic [14:0] h);
        sas_in_t r;
        r        = make_req(OP_RENDER, now, 1'b0);
        r.base_x = x;
        r.base_y = y;
        r.base_w = w;
        r.base_h = h;
        send_req(r);
    endtask

    // Ping-pong direction: run the position past the strip end, bounce it back,
    // keep the backward direction across a play request and run it below zero.
    task automatic test_pingpong_direction();
        gaps_on = 1'b0;
        drain();
        write_reg(CFG_MODE, 32'(MODE_PINGPONG));
        write_reg(CFG_FRAME_COUNT, 32'd20);
        write_reg(CFG_TIME_LIMIT, ALL_ONES32);
        write_reg(CFG_TICK_INTERVAL, ALL_ONES32);
        write_reg(CFG_LOOP_LIMIT, ALL_ONES32);
        write_reg(CFG_HOLD_FRAME, 32'd0);
        play_at(32'd1000, 1'b1);
        repeat (30) render_at(32'd1000);
        drain();
        write_reg(CFG_TICK_INTERVAL, 32'd0);
        render_at(32'd1001);
        drain();
        write_reg(CFG_TICK_INTERVAL, ALL_ONES32);
        // play keeps the backward direction
        play_at(32'd2000, 1'b1);
        repeat (30) render_at(32'd2000);
        drain();
        write_reg(CFG_TICK_INTERVAL, 32'd0);
        render_at(32'd2001);
        render_at(32'd2002);
        gaps_on = 1'b1;
    endtask

    task automatic test_idle_and_extremes();
        sas_in_t r;
        drain();
        write_reg(CFG_MODE, 32'(MODE_LOOP));
        write_reg(CFG_FRAME_COUNT, 32'd0);
        write_reg(CFG_TICK_INTERVAL, 32'd1);
        write_reg(CFG_SIZE_LIMIT, 32'd0);
        write_reg(CFG_SIZE_STEP, 32'd0);
        play_at(32'd0, 1'b0);
        r = '{op: OP_RENDER, now_time: ALL_ONES32, play: 1'b1, base_x: 16'sh8000,
              base_y: 16'sh7FFF, base_w: 15'd0, base_h: 15'h7FFF, base_image: 16'hFFFF};
        send_req(r);
        r = '{op: OP_RENDER, now_time: 32'd0, play: 1'b0, base_x: 16'sh7FFF,
              base_y: 16'sh8000, base_w: 15'h7FFF, base_h: 15'd0, base_image: 16'h0000};
        send_req(r);
        // elapsed time wraps through zero; image index wraps past all ones
        play_at(32'hFFFF_FFF0, 1'b1);
        r = make_req(OP_RENDER, 32'hFFFF_FFF0, 1'b0);
        r.base_image = 16'hFFFF;
        send_req(r);
        r.now_time = 32'd5;
        send_req(r);
        send_req(r);
    endtask

    task automatic test_shrink_grow();
        drain();
        write_reg(CFG_MODE, 32'(MODE_SHRINK));
        write_reg(CFG_FRAME_COUNT, 32'd3);
        write_reg(CFG_TICK_INTERVAL, 32'd0);
        write_reg(CFG_SIZE_LIMIT, 32'd2);
        write_reg(CFG_SIZE_STEP, 32'h0180);
        play_at(32'd100, 1'b1);
        for (int i = 0; i < 4; i++)
            render_rect(32'd100 + i, 16'h7FFF, 16'h8000, 15'd0, 15'h7FFF);
        // grow starts from the size shrink left behind
        drain();
        write_reg(CFG_MODE, 32'(MODE_GROW));
        write_reg(CFG_SIZE_LIMIT, 32'd3);
        write_reg(CFG_SIZE_STEP, 32'h0100);
        for (int i = 0; i < 4; i++)
            render_rect(32'd200 + i, 16'h8000, 16'h7FFF, 15'h7FFF, 15'd0);
    endtask

    task automatic test_pingpong();
        drain();
        write_reg(CFG_MODE, 32'(MODE_PINGPONG));
        write_reg(CFG_FRAME_COUNT, 32'd2);
        write_reg(CFG_TICK_INTERVAL, 32'd0);
        play_at(32'd300, 1'b1);
        for (int i = 0; i < 6; i++)
            render_at(32'd300 + i);
    endtask

    task automatic test_limits();
        drain();
        write_reg(CFG_MODE, 32'(MODE_LOOP));
        write_reg(CFG_FRAME_COUNT, 32'd1);
        write_reg(CFG_LOOP_LIMIT, 32'd1);
        play_at(32'd400, 1'b1);
        repeat (3) render_at(32'd401);
        drain();
        write_reg(CFG_LOOP_LIMIT, ALL_ONES32);
        write_reg(CFG_TIME_LIMIT, 32'd0);
        play_at(32'd50, 1'b1);
        render_at(32'd50);
        render_at(32'd51);
    endtask

    task automatic test_hold_frame();
        drain();
        write_reg(CFG_TIME_LIMIT, ALL_ONES32);
        write_reg(CFG_FRAME_COUNT, 32'd4);
        write_reg(CFG_HOLD_FRAME, 32'd1);
        play_at(32'd500, 1'b1);
        repeat (3) render_at(32'd500);
    endtask

    function automatic logic [31:0] pick_word(input int lo_pct, input logic [31:0] lo_max,
                                              input logic [31:0] top);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return top;
        if (r < 20 + lo_pct)
            return $urandom_range(0, lo_max);
        return $urandom & top;
    endfunction

    task automatic random_settings();
        int r;
        r = $urandom_range(0, 9);
        write_reg(CFG_MODE, $urandom_range(0, 3));
        if (r < 7)
            write_reg(CFG_FRAME_COUNT, $urandom_range(1, 8));
        else if (r == 7)
            write_reg(CFG_FRAME_COUNT, 32'd0);
        else if (r == 8)
            write_reg(CFG_FRAME_COUNT, $urandom_range(SAS_MAX_FRAMES - 1, SAS_MAX_FRAMES));
        else
            write_reg(CFG_FRAME_COUNT, $urandom_range(SAS_MAX_FRAMES + 1, 8191));
        write_reg(CFG_TIME_LIMIT, ($urandom_range(0, 1) == 0) ? ALL_ONES32
                                                            : pick_word(50, 200, ALL_ONES32));
        write_reg(CFG_TICK_INTERVAL, pick_word(65, 4, ALL_ONES32));
        write_reg(CFG_LOOP_LIMIT, ($urandom_range(0, 2) == 0) ? ALL_ONES32
                                                            : pick_word(60, 6, ALL_ONES32));
        write_reg(CFG_HOLD_FRAME, ($urandom_range(0, 6) == 0) ? 32'd1 : 32'd0);
        write_reg(CFG_SIZE_LIMIT, pick_word(60, 8, 32'hFFFF));
        write_reg(CFG_SIZE_STEP, pick_word(60, 32'h300, 32'hFFFF));
    endtask

    // Phases of fresh settings, each a play request followed by renders at advancing times,
    // with a sprinkling of replays and renders at arbitrary times.
    task automatic test_random_sequences(input int n_items);
        int          sent;
        int          r;
        logic [31:0] t;
        sent = 0;
        while (sent < n_items)
        begin
            drain();
            random_settings();
            gaps_on = ($urandom_range(0, 4) != 0);
            t = $urandom;
            play_at(t, 1'b1);
            sent++;
            repeat ($urandom_range(20, 60))
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    play_at(t, $urandom_range(0, 9) != 0);
                end
                else if (r < 9)
                begin
                    render_at($urandom);
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 90)
                        t = t + $urandom_range(0, 3);
                    else if (r < 98)
                        t = t + $urandom_range(4, 1000);
                    else
                        t = t + $urandom;
                    render_at(t);
                end
                sent++;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        gaps_on         = 1'b1;
        mismatches      = 0;
        cycle_count     = 0;
        regs            = '0;
        regs.frame_count   = 13'd1;
        regs.time_limit    = ALL_ONES32;
        regs.tick_interval = 32'd1;
        regs.loop_limit    = ALL_ONES32;
        seq_playing     = 1'b0;
        seq_limit_start = '0;
        seq_tick_start  = '0;
        seq_frame       = 0;
        seq_loops       = '0;
        seq_size        = '0;
        seq_fwd         = 1'b1;
        seq_ended       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_pingpong_direction();
        test_idle_and_extremes();
        test_shrink_grow();
        test_pingpong();
        test_limits();
        test_hold_frame();
        test_random_sequences(550);

        drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && pending_frames.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sas_pkg.sv
sv/sas_step.sv
sv/sprite_animation_sequencer.sv
sv/sas_checker.sv
test/tb_sprite_animation_sequencer.sv
